FILE: hdl/rfd_pkg.sv
// Shared types, constants and helpers for the realtime feedback deframer.
// Depends on nothing; the front, queue, back and top level files import it.
package rfd_pkg;

	localparam logic [7:0] HEADER_CHAR = 8'h2A;
	localparam int         MOTORS      = 4;
	localparam logic [3:0] COUNT_MAX   = 4'd15;
	localparam logic [2:0] GROUP_ALL   = 3'd5;
	localparam int         CFG_INDEX_W = 2;
	localparam int         CFG_DATA_W  = 4;

	// Register indexes of the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GROUP_SELECT  = 2'd0,
		REG_VELOCITY_MASK = 2'd1,
		REG_POSITION_MASK = 2'd2,
		REG_TEMP_ENABLE   = 2'd3
	} cfg_reg_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_LENGTH = 2'd1,
		ST_HEADER = 2'd2
	} status_t;

	// Role of one byte within the block layout
	typedef enum logic [2:0] {
		K_NONE   = 3'd0,
		K_HEADER = 3'd1,
		K_VEL    = 3'd2,
		K_POS_HI = 3'd3,
		K_POS_LO = 3'd4,
		K_TEMP   = 3'd5
	} kind_t;

	typedef struct packed {
		logic [2:0] group_select;
		logic [3:0] velocity_mask;
		logic [3:0] position_mask;
		logic       temperature_enable;
	} cfg_t;

	// One classified byte on its way from front to back
	typedef struct packed {
		kind_t      kind;
		logic [1:0] motor;
		logic [7:0] data;
		logic       last;
		logic       mismatch;
	} entry_t;

	// Motors that belong to a group code; unused codes select none
	function automatic logic [3:0] group_members(input logic [2:0] group);
		logic [3:0] mem;
		unique case (group)
			3'd0: mem = 4'b0001;
			3'd1: mem = 4'b0010;
			3'd2: mem = 4'b0100;
			3'd3: mem = 4'b1000;
			3'd4: mem = 4'b0111;
			3'd5: mem = 4'b1111;
			default: mem = 4'b0000;
		endcase
		return mem;
	endfunction

endpackage

FILE: hdl/rfd_stream_if.sv
// Valid/ready channel interfaces for the deframer byte input and result output.
// Depends on nothing.
interface rfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       block_end;

	modport source (output valid, output data_byte, output block_end, input ready);
	modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface rfd_out_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [7:0]  velocity_f1;
	logic signed [7:0]  velocity_f2;
	logic signed [7:0]  velocity_f3;
	logic signed [7:0]  velocity_spread;
	logic        [15:0] position_f1;
	logic        [15:0] position_f2;
	logic        [15:0] position_f3;
	logic        [15:0] position_spread;
	logic signed [7:0]  temperature;

	modport source (output valid, output status, output velocity_f1, output velocity_f2,
		output velocity_f3, output velocity_spread, output position_f1, output position_f2,
		output position_f3, output position_spread, output temperature, input ready);
	modport sink (input valid, input status, input velocity_f1, input velocity_f2,
		input velocity_f3, input velocity_spread, input position_f1, input position_f2,
		input position_f3, input position_spread, input temperature, output ready);
endinterface

FILE: hdl/rfd_front.sv
// Front end: accepts bytes, tracks the position in the block, classifies each byte.
// Depends on rfd_pkg and rfd_in_if.
module rfd_front import rfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	rfd_in_if.sink in_ch,
	input  cfg_t   cfg,
	input  logic   q_full,
	output logic   q_push,
	output entry_t q_entry
);

	logic [3:0] byte_count_q;
	logic [3:0] count_next;
	logic [3:0] grp;
	logic [3:0] off;
	logic [3:0] exp_len;
	kind_t      kind;
	logic [1:0] motor;

	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;

	// Walk the layout and find the field that sits at the current position
	always_comb begin
		grp   = group_members(cfg.group_select);
		off   = 4'd1;
		kind  = K_NONE;
		motor = 2'd0;
		for (int m = 0; m < MOTORS; m++) begin
			if (grp[m] && cfg.velocity_mask[m]) begin
				if (byte_count_q == off) begin
					kind  = K_VEL;
					motor = 2'(m);
				end
				off = off + 4'd1;
			end
			if (grp[m] && cfg.position_mask[m]) begin
				if (byte_count_q == off) begin
					kind  = K_POS_HI;
					motor = 2'(m);
				end else if (byte_count_q == off + 4'd1) begin
					kind  = K_POS_LO;
					motor = 2'(m);
				end
				off = off + 4'd2;
			end
		end
		if (cfg.temperature_enable && byte_count_q == off) begin
			kind = K_TEMP;
		end
		exp_len = off + {3'b000, cfg.temperature_enable};
		if (byte_count_q == 4'd0) begin
			kind = K_HEADER;
		end
	end

	// Saturating count after this byte; compare against the expected length
	assign count_next = (byte_count_q == COUNT_MAX) ? COUNT_MAX : byte_count_q + 4'd1;

	always_comb begin
		q_entry.kind     = kind;
		q_entry.motor    = motor;
		q_entry.data     = in_ch.data_byte;
		q_entry.last     = in_ch.block_end;
		q_entry.mismatch = (count_next != exp_len);
	end

	// Advance the byte position; restart after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 4'd0;
		end else if (q_push) begin
			if (in_ch.block_end) begin
				byte_count_q <= 4'd0;
			end else begin
				byte_count_q <= count_next;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && in_ch.block_end) |=> (byte_count_q == 4'd0))
		else $error("byte position did not restart after the last byte");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !in_ch.block_end && byte_count_q == COUNT_MAX) |=> (byte_count_q == COUNT_MAX))
		else $error("byte position left saturation inside a block");

endmodule

FILE: hdl/rfd_queue.sv
// Short FIFO of classified bytes between the front and back ends.
// Depends on rfd_pkg.
module rfd_queue import rfd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output entry_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue fill count beyond depth");

endmodule

FILE: hdl/rfd_back.sv
// Back end: latches field values from classified bytes, builds the result on the last byte.
// Depends on rfd_pkg and rfd_out_if.
module rfd_back import rfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_empty,
	input  entry_t   q_head,
	output logic     q_pop,
	rfd_out_if.source out_ch
);

	logic [7:0]  vel_q [MOTORS];
	logic [15:0] pos_q [MOTORS];
	logic [7:0]  temp_q;
	logic [7:0]  hold_q;
	logic        header_ok_q;
	logic [7:0]  vel_n [MOTORS];
	logic [15:0] pos_n [MOTORS];
	logic [7:0]  temp_n;
	logic [7:0]  hold_n;
	logic        header_ok_n;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  out_vel_q [MOTORS];
	logic [15:0] out_pos_q [MOTORS];
	logic [7:0]  out_temp_q;

	logic        out_free;
	logic        load;
	logic [3:0]  grp;
	status_t     status_n;

	assign out_free = !out_valid_q || out_ch.ready;
	assign q_pop    = !q_empty && (!q_head.last || out_free);
	assign load     = q_pop && q_head.last;
	assign grp      = group_members(cfg.group_select);

	// Apply one classified byte to the stores
	always_comb begin
		vel_n       = vel_q;
		pos_n       = pos_q;
		temp_n      = temp_q;
		hold_n      = hold_q;
		header_ok_n = header_ok_q;
		unique case (q_head.kind)
			K_HEADER: begin
				for (int m = 0; m < MOTORS; m++) begin
					vel_n[m] = 8'd0;
					pos_n[m] = 16'd0;
				end
				temp_n      = 8'd0;
				hold_n      = 8'd0;
				header_ok_n = (q_head.data == HEADER_CHAR);
			end
			K_VEL:    vel_n[q_head.motor] = q_head.data;
			K_POS_HI: hold_n = q_head.data;
			K_POS_LO: pos_n[q_head.motor] = {hold_q, q_head.data};
			K_TEMP:   temp_n = q_head.data;
			default: ;
		endcase
		// Length check wins over the header check
		if (q_head.mismatch) begin
			status_n = ST_LENGTH;
		end else if (header_ok_n) begin
			status_n = ST_OK;
		end else begin
			status_n = ST_HEADER;
		end
	end

	// Update the stores on each transfer out of the queue
	always_ff @(posedge clk) begin
		if (q_pop) begin
			vel_q  <= vel_n;
			pos_q  <= pos_n;
			temp_q <= temp_n;
			hold_q <= hold_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_ok_q <= 1'b0;
		end else if (q_pop) begin
			header_ok_q <= header_ok_n;
		end
	end

	// Capture the gated result on the last byte
	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= status_n;
			for (int m = 0; m < MOTORS; m++) begin
				out_vel_q[m] <= (grp[m] && cfg.velocity_mask[m]) ? vel_n[m] : 8'd0;
				out_pos_q[m] <= (grp[m] && cfg.position_mask[m]) ? pos_n[m] : 16'd0;
			end
			out_temp_q <= cfg.temperature_enable ? temp_n : 8'd0;
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = status_q;
	assign out_ch.velocity_f1     = $signed(out_vel_q[0]);
	assign out_ch.velocity_f2     = $signed(out_vel_q[1]);
	assign out_ch.velocity_f3     = $signed(out_vel_q[2]);
	assign out_ch.velocity_spread = $signed(out_vel_q[3]);
	assign out_ch.position_f1     = out_pos_q[0];
	assign out_ch.position_f2     = out_pos_q[1];
	assign out_ch.position_f3     = out_pos_q[2];
	assign out_ch.position_spread = out_pos_q[3];
	assign out_ch.temperature     = $signed(out_temp_q);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !load)
		else $error("result overwritten before its transfer");

endmodule

FILE: hdl/realtime_feedback_deframer_core.sv
// Realtime feedback deframer top level: configuration registers, front, queue, back.
// Path: each byte is registered into the queue; the back takes it from the queue head and,
// on the last byte of a block, registers the result and holds it valid until its transfer.
// Throughput: one byte per cycle while the queue is not full; the front classifies from a
// byte counter and layout decode, the back latches fields, and the queue lets either side stall alone.
// Reset: byte counter, queue, result valid and header flag clear; configuration returns
// to group all four with every feedback field disabled.
module realtime_feedback_deframer_core import rfd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	rfd_in_if.sink                 in_ch,
	rfd_out_if.source              out_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t   cfg_q;
	logic   q_full;
	logic   q_empty;
	logic   q_push;
	logic   q_pop;
	entry_t q_entry;
	entry_t q_head;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_select       <= GROUP_ALL;
			cfg_q.velocity_mask      <= 4'd0;
			cfg_q.position_mask      <= 4'd0;
			cfg_q.temperature_enable <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GROUP_SELECT:  cfg_q.group_select       <= cfg_data[2:0];
				REG_VELOCITY_MASK: cfg_q.velocity_mask      <= cfg_data[3:0];
				REG_POSITION_MASK: cfg_q.position_mask      <= cfg_data[3:0];
				REG_TEMP_ENABLE:   cfg_q.temperature_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	rfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (q_head)
	);

	rfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule
